[rtl/gclp_pkg.sv]
// Package for the G-code line parser: sequencer states, parse phases,
// character codes and the power-of-ten table. No dependencies.
package gclp_pkg;

  localparam int unsigned MaxWordsDef    = 8;
  localparam int unsigned MaxFracDigitsDef = 8;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUA    = 8'h41;
  localparam logic [7:0] ChUZ    = 8'h5A;
  localparam logic [7:0] ChLa    = 8'h61;
  localparam logic [7:0] ChLz    = 8'h7A;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChY     = 8'h59;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChM     = 8'h4D;

  localparam logic [1:0] StatMid  = 2'd0;
  localparam logic [1:0] StatDone = 2'd1;
  localparam logic [1:0] StatErr  = 2'd2;

  typedef enum logic [1:0] {
    PH_LETTER,
    PH_NUMSTART,
    PH_DIGITS,
    PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_APPLY,
    ST_CMD
  } state_e;

  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] r;
    unique case (n)
      4'd0: r = 30'd1;
      4'd1: r = 30'd10;
      4'd2: r = 30'd100;
      4'd3: r = 30'd1000;
      4'd4: r = 30'd10000;
      4'd5: r = 30'd100000;
      4'd6: r = 30'd1000000;
      4'd7: r = 30'd10000000;
      4'd8: r = 30'd100000000;
      4'd9: r = 30'd1000000000;
      default: r = 30'd1;
    endcase
    return r;
  endfunction

endpackage

[rtl/gclp_char_if.sv]
// Input channel of the G-code line parser: one text byte per item.
// No dependencies.
interface gclp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

[rtl/gclp_res_if.sv]
// Result channel of the G-code line parser: one result item per byte.
// No dependencies.
interface gclp_res_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [7:0]  cmd_letter;
  logic        [15:0] cmd_number;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_feed;
  logic signed [15:0] out_s;
  logic               out_relative;
  modport source (output valid, output status, output cmd_letter, output cmd_number,
                  output out_x, output out_y, output out_feed, output out_s,
                  output out_relative, input ready);
  modport sink (input valid, input status, input cmd_letter, input cmd_number,
                input out_x, input out_y, input out_feed, input out_s,
                input out_relative, output ready);
endinterface

[rtl/gcode_line_parser_unit.sv]
// G-code line parser top level. Uses gclp_pkg, gclp_char_if, gclp_res_if.
// Holds the byte parser, word store, line sequencer and shared divider.
//
// One byte is taken per item; a byte that does not end a line gives its
// result in the cycle after acceptance. A line end runs a sequencer over the
// stored words after the first: for each X, Y, F or S word a multiply and,
// when fraction digits remain, a rounding add and a restoring division;
// then the command check on the first word. The divider is shared by all
// words of the line. A new byte is accepted when the sequencer is idle and
// the result register is empty or being emptied. start_feed is written
// through the APB port and loads the feed target.
module gcode_line_parser_unit
  import gclp_pkg::*;
#(
  parameter int unsigned MAX_WORDS       = MaxWordsDef,
  parameter int unsigned MAX_FRAC_DIGITS = MaxFracDigitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gclp_char_if.sink         in_i,
  gclp_res_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned IdxW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned KW    = $clog2(MAX_WORDS + 1);
  localparam int unsigned FracW = $clog2(MAX_FRAC_DIGITS + 2);
  localparam int unsigned DivW  = 33;
  localparam int unsigned CntW  = 6;

  state_e state_q, state_d;
  phase_e phase_q;

  logic [IdxW-1:0]  widx_q;
  logic [7:0]       wlet_q  [MAX_WORDS];
  logic [31:0]      wman_q  [MAX_WORDS];
  logic [FracW-1:0] wfrac_q [MAX_WORDS];
  logic             wneg_q  [MAX_WORDS];

  logic [31:0] tx_q, ty_q, tfeed_q;
  logic [15:0] spin_q;
  logic        rel_q, relb_q;
  logic [30:0] start_feed_q;

  logic [KW-1:0]   k_q;
  logic [7:0]      let_q;
  logic            neg_q;
  logic [9:0]      mult_q;
  logic [3:0]      fr_q;
  logic [31:0]     prod_q;
  logic [DivW-1:0] dvd_q;
  logic [30:0]     rem_q;
  logic [29:0]     dvs_q;
  logic [CntW-1:0] cnt_q;

  logic        ov_q;
  logic [1:0]  st_q;
  logic [7:0]  cl_q;
  logic [15:0] cn_q;

  logic       acc, cfg_wr;
  logic [IdxW-1:0] ridx;
  logic [7:0] c, cu;
  logic       is_end, is_blank, is_num, is_let;
  logic [31:0] dval;
  logic [3:0] fraw, fcan;
  logic [31:0] sv;
  logic [31:0] t_diff;
  logic [31:0] n0;
  logic        cmd_ok;

  assign pready = 1'b1;
  assign prdata = {1'b0, start_feed_q};
  assign cfg_wr = psel & penable & pwrite;

  assign in_i.ready = (state_q == ST_IDLE) && (!ov_q || out_o.ready);
  assign acc        = in_i.valid & in_i.ready;

  assign out_o.valid        = ov_q;
  assign out_o.status       = st_q;
  assign out_o.cmd_letter   = cl_q;
  assign out_o.cmd_number   = cn_q;
  assign out_o.out_x        = tx_q;
  assign out_o.out_y        = ty_q;
  assign out_o.out_feed     = tfeed_q;
  assign out_o.out_s        = spin_q;
  assign out_o.out_relative = relb_q;

  assign ridx     = (state_q == ST_IDLE) ? widx_q : k_q[IdxW-1:0];
  assign c        = in_i.char_in;
  assign is_end   = (c == ChLf) || (c == ChCr);
  assign is_blank = (c == ChSpace) || (c == ChTab);
  assign is_num   = (c >= Ch0) && (c <= Ch9);
  assign cu       = ((c >= ChLa) && (c <= ChLz)) ? c - 8'd32 : c;
  assign is_let   = (cu >= ChUA) && (cu <= ChUZ);
  assign dval     = {28'd0, c[3:0]};

  always_comb begin
    fraw = 4'd0;
    if (wfrac_q[ridx] != '0) begin
      fraw = 4'(wfrac_q[ridx] - 1'b1);
    end
    if (fraw > 4'd9) begin
      fraw = 4'd9;
    end
    fcan = (fraw > 4'd3) ? 4'd3 : fraw;
  end

  assign sv     = neg_q ? (32'd0 - dvd_q[31:0]) : dvd_q[31:0];
  assign t_diff = {rem_q, dvd_q[DivW-1]} - {2'b00, dvs_q};
  assign n0     = wman_q[0];

  always_comb begin
    cmd_ok = 1'b0;
    if (wlet_q[0] == ChG) begin
      cmd_ok = (n0 == 32'd0) || (n0 == 32'd1) || (n0 == 32'd28) ||
               (n0 == 32'd90) || (n0 == 32'd91);
    end else if (wlet_q[0] == ChM) begin
      cmd_ok = (n0 == 32'd0) || (n0 == 32'd112) || (n0 == 32'd114) ||
               (n0 == 32'd119) || (n0 == 32'd202) || (n0 == 32'd222);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && is_end && (phase_q == PH_DIGITS)) begin
          state_d = ST_LINE;
        end
      end
      ST_LINE: begin
        if (k_q > KW'(widx_q)) begin
          state_d = ST_CMD;
        end else if ((wlet_q[ridx] == ChX) || (wlet_q[ridx] == ChY) ||
                     (wlet_q[ridx] == ChF) || (wlet_q[ridx] == ChS)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = ST_PREP;
      ST_PREP:  state_d = (fr_q == 4'd0) ? ST_APPLY : ST_DIV;
      ST_DIV:   state_d = (cnt_q == CntW'(DivW - 1)) ? ST_APPLY : ST_DIV;
      ST_APPLY: state_d = ST_LINE;
      ST_CMD:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LETTER;
      widx_q       <= '0;
      tx_q         <= '0;
      ty_q         <= '0;
      tfeed_q      <= '0;
      spin_q       <= '0;
      rel_q        <= 1'b0;
      relb_q       <= 1'b0;
      start_feed_q <= '0;
      ov_q         <= 1'b0;
      st_q         <= StatMid;
      cl_q         <= '0;
      cn_q         <= '0;
      k_q          <= '0;
      for (int i = 0; i < MAX_WORDS; i++) begin
        wlet_q[i]  <= '0;
        wman_q[i]  <= '0;
        wfrac_q[i] <= '0;
        wneg_q[i]  <= 1'b0;
      end
    end else begin
      if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (cfg_wr && (paddr[2] == 1'b0)) begin
        start_feed_q <= pwdata[30:0];
        tfeed_q      <= {1'b0, pwdata[30:0]};
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            relb_q <= rel_q;
            cl_q   <= '0;
            cn_q   <= '0;
            st_q   <= is_end ? StatErr : StatMid;
            unique case (phase_q)
              PH_LETTER: begin
                if (!is_blank) begin
                  if (is_let) begin
                    wlet_q[ridx] <= cu;
                    phase_q      <= PH_NUMSTART;
                  end else begin
                    phase_q <= PH_ERR;
                  end
                end
              end
              PH_NUMSTART: begin
                if (c == ChMinus) begin
                  wneg_q[ridx] <= 1'b1;
                  phase_q      <= PH_DIGITS;
                end else if (is_num) begin
                  wman_q[ridx] <= dval;
                  phase_q      <= PH_DIGITS;
                end else begin
                  phase_q <= PH_ERR;
                end
              end
              PH_DIGITS: begin
                if (is_num) begin
                  if (wfrac_q[ridx] > FracW'(MAX_FRAC_DIGITS)) begin
                    phase_q <= PH_ERR;
                  end else begin
                    wman_q[ridx] <= (wman_q[ridx] << 3) + (wman_q[ridx] << 1) + dval;
                    if (wfrac_q[ridx] != '0) begin
                      wfrac_q[ridx] <= wfrac_q[ridx] + 1'b1;
                    end
                  end
                end else if (is_blank) begin
                  if (32'(widx_q) + 32'd1 >= 32'(MAX_WORDS)) begin
                    phase_q <= PH_ERR;
                  end else begin
                    widx_q  <= widx_q + 1'b1;
                    phase_q <= PH_LETTER;
                  end
                end else if (is_end) begin
                  k_q <= KW'(1);
                  if (rel_q) begin
                    tx_q <= '0;
                    ty_q <= '0;
                  end
                end else if ((c == ChPoint) && (wfrac_q[ridx] == '0)) begin
                  wfrac_q[ridx] <= FracW'(1);
                end else begin
                  phase_q <= PH_ERR;
                end
              end
              PH_ERR: begin
              end
              default: begin
              end
            endcase
            if (!(is_end && (phase_q == PH_DIGITS))) begin
              ov_q <= 1'b1;
              if (is_end) begin
                phase_q <= PH_LETTER;
                widx_q  <= '0;
                for (int i = 0; i < MAX_WORDS; i++) begin
                  wlet_q[i]  <= '0;
                  wman_q[i]  <= '0;
                  wfrac_q[i] <= '0;
                  wneg_q[i]  <= 1'b0;
                end
              end
            end
          end
        end
        ST_LINE: begin
          if (state_d != ST_MUL && state_d != ST_CMD) begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_APPLY: begin
          k_q <= k_q + 1'b1;
          if (let_q == ChX) begin
            tx_q <= sv;
          end else if (let_q == ChY) begin
            ty_q <= sv;
          end else if (let_q == ChF) begin
            tfeed_q <= sv;
          end else begin
            spin_q <= sv[15:0];
          end
        end
        ST_CMD: begin
          ov_q <= 1'b1;
          st_q <= cmd_ok ? StatDone : StatErr;
          cl_q <= wlet_q[0];
          cn_q <= (n0 > 32'd65535) ? 16'hFFFF : n0[15:0];
          if ((wlet_q[0] == ChG) && (n0 == 32'd90)) begin
            rel_q <= 1'b0;
          end else if ((wlet_q[0] == ChG) && (n0 == 32'd91)) begin
            rel_q <= 1'b1;
          end
          phase_q <= PH_LETTER;
          widx_q  <= '0;
          for (int i = 0; i < MAX_WORDS; i++) begin
            wlet_q[i]  <= '0;
            wman_q[i]  <= '0;
            wfrac_q[i] <= '0;
            wneg_q[i]  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // shared datapath: scale, rounding add, restoring divide
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LINE: begin
        let_q <= wlet_q[ridx];
        neg_q <= wneg_q[ridx];
        if ((wlet_q[ridx] == ChX) || (wlet_q[ridx] == ChY)) begin
          mult_q <= 10'(pow10(4'd3 - fcan));
          fr_q   <= fraw - fcan;
        end else begin
          mult_q <= 10'd1;
          fr_q   <= fraw;
        end
      end
      ST_MUL: begin
        prod_q <= 32'(wman_q[ridx] * {22'd0, mult_q});
      end
      ST_PREP: begin
        if (fr_q == 4'd0) begin
          dvd_q <= {1'b0, prod_q};
        end else begin
          dvd_q <= {1'b0, prod_q} + {3'd0, pow10(fr_q) >> 1};
        end
        dvs_q <= pow10(fr_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        cnt_q <= cnt_q + 1'b1;
        if ({rem_q, dvd_q[DivW-1]} >= {2'b00, dvs_q}) begin
          rem_q <= t_diff[30:0];
          dvd_q <= {dvd_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[29:0], dvd_q[DivW-1]};
          dvd_q <= {dvd_q[DivW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[tb/gcode_line_parser_unit_tb.sv]
// Testbench for gcode_line_parser_unit: sends text lines byte by byte and
// checks every result item against a predictor kept in step with the bytes.
// Depends on gclp_pkg, gclp_char_if, gclp_res_if and the RTL top level.
module gcode_line_parser_unit_tb;
  import gclp_pkg::*;

  localparam logic [2:0] RegStartFeed = 3'd0;
  localparam int unsigned NumWords = 8;
  localparam int unsigned FracMax  = 8;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  letter;
    logic [15:0] number;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] feed;
    logic [15:0] s;
    logic        rel;
  } line_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gclp_char_if ci ();
  gclp_res_if  ro ();

  gcode_line_parser_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(ci), .out_o(ro),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  // parser shadow state
  phase_e      ph;
  int unsigned widx;
  logic [7:0]  wlet [NumWords];
  logic [31:0] wman [NumWords];
  int unsigned wfrac [NumWords];
  logic        wneg [NumWords];
  logic [31:0] tgt_x, tgt_y, tgt_feed, feed_reg;
  logic [15:0] spindle;
  logic        rel_mode;

  line_res_t   expected_q[$];
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 0;

  function automatic void clear_line();
    ph = PH_LETTER;
    widx = 0;
    for (int k = 0; k < NumWords; k++) begin
      wlet[k] = '0; wman[k] = '0; wfrac[k] = 0; wneg[k] = 1'b0;
    end
  endfunction

  function automatic logic [31:0] scaled(int k, int unsigned mult);
    int unsigned f;
    logic [63:0] p;
    logic [31:0] m;
    f = wfrac[k] ? wfrac[k] - 1 : 0;
    if (f > 9) f = 9;
    while (f != 0 && mult % 10 == 0) begin
      mult /= 10; f--;
    end
    m = 32'((64'(wman[k]) * 64'(mult)));
    if (f != 0) begin
      p = 1;
      for (int i = 0; i < f; i++) p *= 10;
      m = 32'((64'(m) + p / 2) / p);
    end
    if (wneg[k]) m = -m;
    return m;
  endfunction

  function automatic bit finish_line();
    logic [31:0] n;
    n = wman[0];
    if (rel_mode) begin
      tgt_x = '0; tgt_y = '0;
    end
    for (int k = 1; k <= widx && k < NumWords; k++)
      case (wlet[k])
        ChX: tgt_x = scaled(k, 1000);
        ChY: tgt_y = scaled(k, 1000);
        ChF: tgt_feed = scaled(k, 1);
        ChS: spindle = 16'(scaled(k, 1));
        default: ;
      endcase
    if (wlet[0] == ChG) begin
      if (n == 90) begin rel_mode = 1'b0; return 1; end
      if (n == 91) begin rel_mode = 1'b1; return 1; end
      return n == 0 || n == 1 || n == 28;
    end
    if (wlet[0] == ChM)
      return n == 0 || n == 112 || n == 114 || n == 119 || n == 202 || n == 222;
    return 0;
  endfunction

  function automatic line_res_t parse_char(logic [7:0] c);
    line_res_t r;
    bit ending, blank, digit, done, ok;
    logic rel_before;
    int unsigned w;
    ending = (c == ChLf || c == ChCr);
    blank = (c == ChSpace || c == ChTab);
    digit = (c >= Ch0 && c <= Ch9);
    done = 0; ok = 0;
    rel_before = rel_mode;
    r = '0;
    w = widx < NumWords ? widx : 0;
    case (ph)
      PH_LETTER: if (!blank) begin
        if (c >= ChLa && c <= ChLz) c -= 8'd32;
        if (c >= ChUA && c <= ChUZ) begin
          wlet[w] = c; ph = PH_NUMSTART;
        end else ph = PH_ERR;
      end
      PH_NUMSTART:
        if (c == ChMinus) begin wneg[w] = 1'b1; ph = PH_DIGITS; end
        else if (digit) begin wman[w] = 32'(c - Ch0); ph = PH_DIGITS; end
        else ph = PH_ERR;
      PH_DIGITS:
        if (digit) begin
          if (wfrac[w] > FracMax) ph = PH_ERR;
          else begin
            wman[w] = wman[w] * 10 + 32'(c - Ch0);
            if (wfrac[w] != 0) wfrac[w]++;
          end
        end else if (blank) begin
          if (w + 1 >= NumWords) ph = PH_ERR;
          else begin widx = w + 1; ph = PH_LETTER; end
        end else if (ending) begin
          done = 1;
          ok = finish_line();
          r.letter = wlet[0];
          r.number = wman[0] > 65535 ? 16'hFFFF : wman[0][15:0];
        end else if (c == ChPoint && wfrac[w] == 0) wfrac[w] = 1;
        else ph = PH_ERR;
      default: ;
    endcase
    r.status = StatMid;
    if (ending) begin
      r.status = (done && ok) ? StatDone : StatErr;
      clear_line();
    end
    r.x = tgt_x; r.y = tgt_y; r.feed = tgt_feed; r.s = spindle; r.rel = rel_before;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (%0t)", what, got, want, $realtime);
    errors++;
  endtask

  // result side: random stalls and checking
  int unsigned stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    line_res_t e;
    if (!rst_ni) begin
      ro.ready <= 1'b0;
      stall = 0;
    end else begin
      if (ro.valid && ro.ready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result item (%0t)", $realtime);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (ro.status !== e.status) report("status", ro.status, e.status);
          if (ro.cmd_letter !== e.letter) report("cmd_letter", ro.cmd_letter, e.letter);
          if (ro.cmd_number !== e.number) report("cmd_number", ro.cmd_number, e.number);
          if (ro.out_x !== e.x) report("out_x", ro.out_x, e.x);
          if (ro.out_y !== e.y) report("out_y", ro.out_y, e.y);
          if (ro.out_feed !== e.feed) report("out_feed", ro.out_feed, e.feed);
          if (ro.out_s !== e.s) report("out_s", ro.out_s, e.s);
          if (ro.out_relative !== e.rel) report("out_relative", ro.out_relative, e.rel);
        end
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end else if (stall > 0) stall--;
      ro.ready <= (stall == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((ci.valid && ci.ready) || (ro.valid && ro.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      ci.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ci.valid <= 1'b1;
    ci.char_in <= c;
    do @(posedge clk_i); while (!ci.ready);
    expected_q.push_back(parse_char(c));
    bytes_sent++;
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
  endtask

  task automatic wait_drained();
    ci.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_start_feed(logic [30:0] v);
    wait_drained();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RegStartFeed; pwdata <= {1'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    feed_reg = {1'b0, v};
    tgt_feed = feed_reg;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] any_case(logic [7:0] l);
    return $urandom_range(0, 3) == 0 ? l + 8'd32 : l;
  endfunction

  task automatic send_random_line();
    logic [7:0] buf_q[$];
    int unsigned nw, nd, pt;
    int unsigned cmds[10] = '{0, 1, 28, 90, 91, 112, 114, 119, 202, 222};
    logic [7:0] lets[4] = '{ChX, ChY, ChF, ChS};
    string num;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) buf_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      buf_q.push_back(any_case(8'($urandom_range(0, 7) == 0 ? $urandom_range(ChUA, ChUZ)
                                  : ($urandom_range(0, 1) ? ChG : ChM))));
      num.itoa($urandom_range(0, 5) == 0 ? $urandom_range(0, 99999) :
               cmds[$urandom_range(0, 9)]);
      for (int i = 0; i < num.len(); i++) buf_q.push_back(num[i]);
      nw = $urandom_range(0, 8);
      for (int w = 0; w < nw; w++) begin
        buf_q.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
        if ($urandom_range(0, 15) == 0) buf_q.push_back(ChSpace);
        buf_q.push_back(any_case(8'($urandom_range(0, 7) == 0 ?
                                    $urandom_range(ChUA, ChUZ) : lets[$urandom_range(0, 3)])));
        if ($urandom_range(0, 2) == 0) buf_q.push_back(ChMinus);
        nd = $urandom_range(1, $urandom_range(0, 4) == 0 ? 14 : 6);
        pt = $urandom_range(0, nd + 2);
        for (int d = 0; d < nd; d++) begin
          if (d == pt && d != 0) buf_q.push_back(ChPoint);
          buf_q.push_back(8'(Ch0 + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 30) == 0) buf_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    buf_q.push_back($urandom_range(0, 3) == 0 ? ChCr : ChLf);
    foreach (buf_q[i]) send_byte(buf_q[i]);
  endtask

  task automatic test_directed();
    send_text("G1 X1.5 Y-2.25 F300 S1200\n");
    send_text("g91 x0.0005 y-0.0005\n");
    send_text("G1 X12.34567891 Y1.123456789\n");
    send_text("G90\r\n");
    send_text("M112 S65535.5\n");
    send_text("G1 X99999999999 Y-4294967\n");
    send_text("G1 X1 Y1 X1 Y1 X1 Y1 F1 S1\n");
    send_text("G0 X1.2.3\n");
    send_text("G28 #\n");
    send_text("\n");
    send_text("G1 \n");
    send_text("G\n");
    send_text("Q5\n");
    send_text("M114 Z3 F-7.5\n");
    send_text("M119 X-.5\n");
    send_text("m202\tS-70000\rM222 M0\nM0\n");
    send_byte(8'hFF); send_byte(8'h00); send_byte(ChLf);
  endtask

  task automatic test_start_feed();
    write_start_feed(31'h7FFF_FFFF);
    send_text("G1 X2\nG1 F12\n");
    write_start_feed('0);
    send_text("G1 Y3\n");
    write_start_feed(31'($urandom));
    repeat (10) send_random_line();
  endtask

  task automatic test_random(int unsigned n);
    int unsigned stop;
    stop = bytes_sent + n;
    while (bytes_sent < stop) send_random_line();
  endtask

  task automatic test_back_to_back(int unsigned n);
    no_idle = 1;
    test_random(n);
    wait_drained();
    no_idle = 0;
  endtask

  initial begin
    ci.valid <= 1'b0;
    ci.char_in <= '0;
    clear_line();
    tgt_x = '0; tgt_y = '0; feed_reg = '0; tgt_feed = '0;
    spindle = '0; rel_mode = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_start_feed();
    test_random(600);
    test_back_to_back(200);
    write_start_feed(31'd1);
    test_random(460);
    wait_drained();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[files.f]
rtl/gclp_pkg.sv
rtl/gclp_char_if.sv
rtl/gclp_res_if.sv
rtl/gcode_line_parser_unit.sv
tb/gcode_line_parser_unit_tb.sv
